[hw/rtl/lost_pkg.sv]
// Shared types and constants for the live order size tracker.
// No dependencies.
package lost_pkg;
  localparam int unsigned KeyW  = 31;
  localparam int unsigned SizeW = 32;
  localparam int unsigned TimeW = 52;
  localparam int unsigned TotW  = 40;
  localparam logic [31:0] HashMul = 32'h9E3779B1;

  localparam logic [1:0] TypeConfirm = 2'd1;
  localparam logic [1:0] TypeExec    = 2'd2;
  localparam logic [1:0] TypeCancel  = 2'd3;
  localparam logic [1:0] SideBuy     = 2'd0;
  localparam logic [1:0] SideSell    = 2'd1;
  localparam logic       RegWinStart = 1'b0;
  localparam logic       RegWinEnd   = 1'b1;

  typedef struct packed {
    logic load;     // start probe walk, check window
    logic probe;    // issue probe read
    logic check;    // evaluate registered read
    logic commit;   // write entry and totals
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;     // no table walk needed
    logic done;     // probing finished
    logic init;     // valid bits still being cleared
  } ctl_sts_t;
endpackage

[hw/rtl/live_order_size_tracker.sv]
// Live order size tracker: one result per request, strobed by done_o.
// Without a table walk a request passes the load, probe and commit states; with one it
// also probes 1 to MAX_PROBES slots. A new request is accepted once busy_o drops.
// Reset zeroes totals and window, then a clearing pass holds busy_o high while
// it zeroes the slot valid bits.
// The receiver cannot stall results.
module live_order_size_tracker #(
  parameter int unsigned ORDER_SLOTS = 1024,
  parameter int unsigned MAX_PROBES  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [30:0] order_id_i,
  input  logic [1:0]  side_i,
  input  logic signed [31:0] remaining_size_i,
  input  logic [51:0] event_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [51:0] cfg_data_i,
  output logic        done_o,
  output logic signed [39:0] bid_live_size_o,
  output logic signed [39:0] ask_live_size_o,
  output logic        in_window_o,
  output logic        table_full_o
);
  import lost_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lost_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_o(cmd), .sts_i(sts)
  );

  lost_dp #(.ORDER_SLOTS(ORDER_SLOTS), .MAX_PROBES(MAX_PROBES)) u_dp (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .req_type_i, .order_id_i, .side_i, .remaining_size_i, .event_time_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .bid_live_size_o, .ask_live_size_o, .in_window_o, .table_full_o, .done_o
  );
endmodule

[hw/rtl/lost_ctrl.sv]
// Controller state machine for the live order size tracker.
// Depends on lost_pkg.
module lost_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output lost_pkg::ctl_cmd_t cmd_o,
  input  lost_pkg::ctl_sts_t sts_i
);
  import lost_pkg::*;

  typedef enum logic [5:0] {
    StInit   = 6'b000001,
    StIdle   = 6'b000010,
    StLoad   = 6'b000100,
    StProbe  = 6'b001000,
    StCheck  = 6'b010000,
    StCommit = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StInit: begin
        if (!sts_i.init) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) state_d = StLoad;
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d = StProbe;
      end
      StProbe: begin
        if (sts_i.skip) begin
          state_d = StCommit;
        end else begin
          cmd_o.probe = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        if (sts_i.done) state_d = StCommit;
        else begin
          cmd_o.probe = 1'b1;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StInit;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != StIdle);
endmodule

[hw/rtl/lost_dp.sv]
// Datapath: hashed slot table, probe walk, side totals and window check.
// Depends on lost_pkg.
module lost_dp #(
  parameter int unsigned ORDER_SLOTS = 1024,
  parameter int unsigned MAX_PROBES  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   req_type_i,
  input  logic [lost_pkg::KeyW-1:0]    order_id_i,
  input  logic [1:0]                   side_i,
  input  logic signed [lost_pkg::SizeW-1:0] remaining_size_i,
  input  logic [lost_pkg::TimeW-1:0]   event_time_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [lost_pkg::TimeW-1:0]   cfg_data_i,
  input  lost_pkg::ctl_cmd_t           cmd_i,
  output lost_pkg::ctl_sts_t           sts_o,
  output logic signed [lost_pkg::TotW-1:0] bid_live_size_o,
  output logic signed [lost_pkg::TotW-1:0] ask_live_size_o,
  output logic                         in_window_o,
  output logic                         table_full_o,
  output logic                         done_o
);
  import lost_pkg::*;

  localparam int unsigned AW = $clog2(ORDER_SLOTS);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);
  localparam logic [PW-1:0] LastProbe = PW'(MAX_PROBES);
  localparam logic signed [TotW+1:0] TotMax = (42'sd1 <<< (TotW - 1)) - 42'sd1;
  localparam logic signed [TotW+1:0] TotMin = -(42'sd1 <<< (TotW - 1));

  logic [1:0]              type_q;
  logic [KeyW-1:0]         key_q;
  logic [1:0]              side_q;
  logic signed [SizeW-1:0] size_q;
  logic [TimeW-1:0]        time_q;
  logic [TimeW-1:0]        win_start_q, win_end_q;
  logic [AW-1:0]           base_q, addr_q;
  logic [PW-1:0]           pcnt_q;
  logic                    pass_q;
  logic                    found_q, free_ok_q, done_q;
  logic [AW-1:0]           found_slot_q, free_slot_q;
  logic signed [SizeW-1:0] found_rem_q;
  logic signed [TotW-1:0]  bid_q, ask_q;
  logic                    clr_busy_q;
  logic [AW-1:0]           clr_addr_q;

  logic [KeyW-1:0]         mem_key [ORDER_SLOTS];
  logic signed [SizeW-1:0] mem_rem [ORDER_SLOTS];
  logic                    mem_vld [ORDER_SLOTS];
  logic [KeyW-1:0]         rd_key_q;
  logic signed [SizeW-1:0] rd_rem_q;
  logic                    rd_valid_q;
  logic [AW-1:0]           rd_addr_q;

  logic [31:0] hash;
  assign hash = {1'b0, order_id_i} * HashMul;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) begin
      type_q <= req_type_i;
      key_q  <= order_id_i;
      side_q <= side_i;
      size_q <= remaining_size_i;
      time_q <= event_time_i;
      base_q <= hash[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegWinStart) win_start_q <= cfg_data_i;
      else win_end_q <= cfg_data_i;
    end
  end

  // Clear valid bits after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(ORDER_SLOTS - 1)) clr_busy_q <= 1'b0;
    end
  end

  logic is_upd, is_cancel, size_pos;
  assign is_upd    = (type_q == TypeConfirm) || (type_q == TypeExec);
  assign is_cancel = (type_q == TypeCancel);
  assign size_pos  = !size_q[SizeW-1] && (size_q != '0);

  logic hit, miss_free;
  assign hit       = rd_valid_q && (rd_key_q == key_q);
  assign miss_free = !rd_valid_q;

  assign sts_o = '{skip: !pass_q || !(is_upd || is_cancel),
                   done: hit || (pcnt_q == LastProbe),
                   init: clr_busy_q};

  // Probe address, table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      rd_key_q   <= mem_key[addr_q];
      rd_rem_q   <= mem_rem[addr_q];
      rd_valid_q <= mem_vld[addr_q];
      rd_addr_q  <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      addr_q <= '0;
      pass_q <= 1'b0;
      found_q <= 1'b0;
      free_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pcnt_q <= '0;
        addr_q <= base_q;
        found_q <= 1'b0;
        free_ok_q <= 1'b0;
        pass_q <= (win_start_q == '0) || (win_end_q == '0) ||
                  ((time_q >= win_start_q) && (time_q <= win_end_q));
      end
      if (cmd_i.probe) begin
        addr_q <= addr_q + AW'(1);
        pcnt_q <= pcnt_q + PW'(1);
      end
      if (cmd_i.check) begin
        if (hit) found_q <= 1'b1;
        if (miss_free && !free_ok_q) free_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      if (hit) begin
        found_slot_q <= rd_addr_q;
        found_rem_q  <= rd_rem_q;
      end
      if (miss_free && !free_ok_q) free_slot_q <= rd_addr_q;
    end
  end

  // Commit
  logic signed [TotW+1:0] delta, cur, sum, sat;
  logic                   wr_en, clr_en, full;
  logic [AW-1:0]          wr_addr;
  always_comb begin
    delta  = '0;
    wr_en  = 1'b0;
    clr_en = 1'b0;
    full   = 1'b0;
    wr_addr = found_q ? found_slot_q : free_slot_q;
    if (pass_q && is_upd) begin
      delta = (TotW+2)'(size_q) - (found_q ? (TotW+2)'(found_rem_q) : '0);
      if (size_pos) begin
        if (found_q || free_ok_q) wr_en = 1'b1;
        else full = 1'b1;
      end else if (found_q) begin
        clr_en = 1'b1;
      end
    end else if (pass_q && is_cancel && found_q) begin
      delta  = -(TotW+2)'(found_rem_q);
      clr_en = 1'b1;
    end
    cur = (side_q == SideBuy) ? (TotW+2)'(bid_q) : (TotW+2)'(ask_q);
    sum = cur + delta;
    priority if (sum > TotMax) sat = TotMax;
    else if (sum < TotMin) sat = TotMin;
    else sat = sum;
  end

  logic          vld_we, vld_wd;
  logic [AW-1:0] vld_wa;
  assign vld_we = clr_busy_q || (cmd_i.commit && (wr_en || clr_en));
  assign vld_wa = clr_busy_q ? clr_addr_q : wr_addr;
  assign vld_wd = !clr_busy_q && wr_en;

  always_ff @(posedge clk_i) begin
    if (vld_we) mem_vld[vld_wa] <= vld_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_key[wr_addr] <= key_q;
      mem_rem[wr_addr] <= size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_q <= '0;
      ask_q <= '0;
      done_q <= 1'b0;
      in_window_o <= 1'b0;
      table_full_o <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (side_q == SideBuy) bid_q <= sat[TotW-1:0];
        if (side_q == SideSell) ask_q <= sat[TotW-1:0];
        in_window_o <= pass_q;
        table_full_o <= full;
      end
    end
  end

  assign bid_live_size_o = bid_q;
  assign ask_live_size_o = ask_q;
  assign done_o = done_q;
endmodule

[hw/rtl/lost_checker.sv]
// Port-level checks for the live order size tracker.
// Depends on live_order_size_tracker ports only.
module lost_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic in_window_o,
  input logic table_full_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_full_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> in_window_o) else $error("full outside window");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
endmodule

bind live_order_size_tracker lost_checker u_lost_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .in_window_o, .table_full_o
);

[test/testbench.sv]
// Self-checking testbench for the live order size tracker.
// Depends on lost_pkg and live_order_size_tracker; predicts every result in-line.
// Covers the time window, the hashed order table, a full table and saturating totals.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lost_pkg::*;

  localparam int unsigned Slots  = 1024;
  localparam int unsigned Probes = 8;
  localparam int unsigned Limit  = 4000;
  localparam logic [1:0]  TypeOther = 2'd0;
  localparam logic [1:0]  SideNone  = 2'd2;
  localparam longint      TotMax = 64'sd549755813887;
  localparam longint      TotMin = -64'sd549755813888;
  localparam logic [51:0] TimeMax = {52{1'b1}};

  typedef struct {
    logic signed [TotW-1:0] bid;
    logic signed [TotW-1:0] ask;
    logic                   in_win;
    logic                   full;
  } totals_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [KeyW-1:0] order_id = '0;
  logic [1:0] side = '0;
  logic signed [SizeW-1:0] rem_size = '0;
  logic [TimeW-1:0] ev_time = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [TimeW-1:0] cfg_data = '0;
  logic done;
  logic signed [TotW-1:0] bid_size;
  logic signed [TotW-1:0] ask_size;
  logic in_window;
  logic table_full;

  logic            live_valid [Slots];
  logic [KeyW-1:0] live_key [Slots];
  int              live_rem [Slots];
  longint          bid_total;
  longint          ask_total;
  logic [TimeW-1:0] win_start;
  logic [TimeW-1:0] win_end;

  totals_t pending_totals [$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  live_order_size_tracker dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .start_i(start),
    .busy_o(busy),
    .req_type_i(req_type),
    .order_id_i(order_id),
    .side_i(side),
    .remaining_size_i(rem_size),
    .event_time_i(ev_time),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .done_o(done),
    .bid_live_size_o(bid_size),
    .ask_live_size_o(ask_size),
    .in_window_o(in_window),
    .table_full_o(table_full)
  );

  function automatic int unsigned home_slot(logic [KeyW-1:0] key, int unsigned i);
    logic [31:0] h;
    h = {1'b0, key} * HashMul;
    return (h % Slots + i) % Slots;
  endfunction

  function automatic longint clamp_total(longint t);
    if (t > TotMax) return TotMax;
    if (t < TotMin) return TotMin;
    return t;
  endfunction

  function automatic void move_total(logic [1:0] sd, longint delta);
    if (sd == SideBuy) bid_total = clamp_total(bid_total + delta);
    else if (sd == SideSell) ask_total = clamp_total(ask_total + delta);
  endfunction

  function automatic totals_t apply_event(logic [1:0] typ, logic [KeyW-1:0] key,
                                          logic [1:0] sd, logic signed [SizeW-1:0] sz,
                                          logic [TimeW-1:0] t);
    totals_t r;
    int hit;
    int slot;
    longint delta;
    r.in_win = 1'b1;
    r.full = 1'b0;
    if (win_start != 0 && win_end != 0 && (t < win_start || t > win_end)) r.in_win = 1'b0;
    if (r.in_win && typ != TypeOther) begin
      hit = -1;
      for (int i = 0; i < Probes; i++) begin
        slot = home_slot(key, i);
        if (hit < 0 && live_valid[slot] && live_key[slot] == key) hit = slot;
      end
      if (typ == TypeCancel) begin
        if (hit >= 0) begin
          move_total(sd, -longint'(live_rem[hit]));
          live_valid[hit] = 1'b0;
        end
      end else begin
        delta = longint'(sz);
        if (hit >= 0) begin
          delta -= longint'(live_rem[hit]);
          if (sz <= 0) live_valid[hit] = 1'b0;
        end
        if (sz > 0) begin
          if (hit < 0) begin
            for (int i = 0; i < Probes; i++) begin
              slot = home_slot(key, i);
              if (hit < 0 && !live_valid[slot]) hit = slot;
            end
          end
          if (hit >= 0) begin
            live_valid[hit] = 1'b1;
            live_key[hit] = key;
            live_rem[hit] = sz;
          end else begin
            r.full = 1'b1;
          end
        end
        move_total(sd, delta);
      end
    end
    r.bid = bid_total[TotW-1:0];
    r.ask = ask_total[TotW-1:0];
    return r;
  endfunction

  task automatic send_event(logic [1:0] typ, logic [KeyW-1:0] key, logic [1:0] sd,
                            logic signed [SizeW-1:0] sz, logic [TimeW-1:0] t);
    start <= 1'b1;
    req_type <= typ;
    order_id <= key;
    side <= sd;
    rem_size <= sz;
    ev_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_totals.insert(pending_totals.size(), apply_event(typ, key, sd, sz, t));
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) n = 0;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 120);
    else n = $urandom_range(1, 4);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic idx, logic [TimeW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == RegWinStart) win_start = value;
    else win_end = value;
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [KeyW-1:0] pool_key();
    if ($urandom_range(0, 15) == 0) return KeyW'($urandom());
    return KeyW'(($urandom_range(0, 11) << 10) | $urandom_range(0, 23));
  endfunction

  function automatic logic signed [SizeW-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return -$urandom_range(0, 500);
      1: return $urandom();
      2: return 0;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  task automatic test_directed();
    send_event(TypeConfirm, 31'd5, SideBuy, 32'sd100, 52'd1);
    send_event(TypeExec, 31'd5, SideBuy, 32'sd40, 52'd2);
    send_event(TypeConfirm, 31'h7FFFFFFF, SideSell, 32'sh7FFFFFFF, TimeMax);
    send_event(TypeOther, 31'd5, SideBuy, 32'sd7, 52'd3);
    send_event(TypeCancel, 31'd999, SideBuy, 32'sd0, 52'd4);
    send_event(TypeCancel, 31'd5, SideBuy, 32'sd0, 52'd5);
    send_event(TypeExec, 31'h7FFFFFFF, SideSell, 32'sd0, 52'd6);
    send_event(TypeConfirm, 31'd77, SideBuy, 32'sh80000000, 52'd0);
    send_event(TypeConfirm, 31'd78, SideSell, 32'sd0, 52'd7);
    send_event(TypeConfirm, 31'd0, SideNone, 32'sd55, 52'd8);
    send_event(TypeExec, 31'd0, SideNone, 32'sd20, 52'd9);
    send_event(TypeCancel, 31'd0, SideNone, 32'sd0, 52'd10);
    send_event(TypeConfirm, 31'd9, SideSell, 32'sd300, 52'd11);
    send_event(TypeExec, 31'd9, SideSell, -32'sd4, 52'd12);
    send_event(TypeCancel, 31'd9, SideSell, 32'sd0, 52'd13);
    drain();
  endtask

  task automatic test_window();
    write_window(RegWinStart, 52'd1000);
    write_window(RegWinEnd, 52'd2000);
    send_event(TypeConfirm, 31'd20, SideBuy, 32'sd10, 52'd999);
    send_event(TypeConfirm, 31'd20, SideBuy, 32'sd10, 52'd1000);
    send_event(TypeExec, 31'd20, SideBuy, 32'sd5, 52'd2000);
    send_event(TypeCancel, 31'd20, SideBuy, 32'sd0, 52'd2001);
    send_event(TypeCancel, 31'd20, SideBuy, 32'sd0, 52'd1500);
    write_window(RegWinStart, 52'd5000);
    send_event(TypeConfirm, 31'd21, SideSell, 32'sd10, 52'd3000);
    write_window(RegWinStart, 52'd1);
    write_window(RegWinEnd, TimeMax);
    send_event(TypeConfirm, 31'd21, SideSell, 32'sd10, 52'd0);
    send_event(TypeCancel, 31'd21, SideSell, 32'sd0, TimeMax);
    write_window(RegWinStart, 52'd0);
    send_event(TypeConfirm, 31'd22, SideSell, 32'sd8, 52'd0);
    send_event(TypeCancel, 31'd22, SideSell, 32'sd0, 52'd0);
    write_window(RegWinEnd, 52'd0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < Probes + 2; i++)
      send_event(TypeConfirm, KeyW'(300 + i * 1024), SideBuy, 32'sd3, rand_time());
    send_event(TypeConfirm, KeyW'(301), SideSell, 32'sd4, rand_time());
    for (int i = 0; i < Probes + 2; i++)
      send_event(TypeCancel, KeyW'(300 + i * 1024), SideBuy, 32'sd0, rand_time());
    send_event(TypeCancel, KeyW'(301), SideSell, 32'sd0, rand_time());
    drain();
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 257; i++) begin
      send_event(TypeConfirm, KeyW'(32'h40000000 + i), SideSell, 32'sh7FFFFFFF, rand_time());
      if (i % 37 == 0) idle_gap();
    end
    for (int i = 0; i < 132; i++)
      send_event(TypeExec, KeyW'(32'h40000000 + i), SideBuy, 32'sh80000000, rand_time());
    drain();
  endtask

  task automatic test_random();
    for (int n = 0; n < 50; n++) begin
      if (n == 15) begin
        write_window(RegWinStart, 52'h8000000000000);
        write_window(RegWinEnd, TimeMax);
      end
      if (n == 30) begin
        write_window(RegWinStart, 52'd0);
        write_window(RegWinEnd, 52'd0);
      end
      if (n % 25 < 6) begin
        if (n % 25 == 0) start <= 1'b0;
      end else begin
        idle_gap();
      end
      send_event(2'($urandom_range(0, 3)), pool_key(), 2'($urandom_range(0, 2)),
                 rand_size(), rand_time());
    end
  endtask

  always @(posedge clk) begin
    if (done) begin
      if (pending_totals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: bid %0d ask %0d", bid_size, ask_size);
      end else begin
        totals_t want;
        want = pending_totals.pop_front();
        checked++;
        if (want.bid !== bid_size || want.ask !== ask_size ||
            want.in_win !== in_window || want.full !== table_full) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp bid %0d ask %0d win %b full %b, got %0d %0d %b %b",
                     want.bid, want.ask, want.in_win, want.full,
                     bid_size, ask_size, in_window, table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      live_valid[i] = 1'b0;
      live_key[i] = '0;
      live_rem[i] = 0;
    end
    bid_total = 0;
    ask_total = 0;
    win_start = '0;
    win_end = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window();
    test_table_full();
    test_saturation();
    test_random();
    drain();
    repeat (30) @(posedge clk);
    $display("sent %0d events, checked %0d results: window bounds, collisions,", sent, checked);
    $display("full table drops and saturation at both total limits");
    if (errors == 0 && pending_totals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
